// ===== src/spcma_pkg.sv =====
// ============================================================================
// spcma_pkg
// Shared widths, register indexes, reset values and controller types for the
// speed PI controller with moving-average speed estimate.
// ============================================================================
`default_nettype none

package spcma_pkg;

    localparam int EDGE_W = 10;
    localparam int CFG_W  = 16;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 8;
    localparam int SUM_W  = 22;
    localparam int DIV_W  = 24;
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DUTY_W = 16;
    localparam int ADDR_W = 3;

    localparam int MAX_AVG_LEN_DEF  = 64;
    localparam int WARMUP_TICKS_DEF = 100;

    localparam logic [ADDR_W-1:0] REG_VEL_SCALE    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_REF_VELOCITY = 3'd1;
    localparam logic [ADDR_W-1:0] REG_KP_GAIN      = 3'd2;
    localparam logic [ADDR_W-1:0] REG_KI_GAIN      = 3'd3;
    localparam logic [ADDR_W-1:0] REG_DUTY_MAX     = 3'd4;
    localparam logic [ADDR_W-1:0] REG_AVG_LEN      = 3'd5;
    localparam logic [ADDR_W-1:0] REG_WARMUP_DUTY  = 3'd6;
    localparam logic [ADDR_W-1:0] REG_USE_INTEGRAL = 3'd7;

    localparam logic [CFG_W-1:0] RST_VEL_SCALE    = 16'd2323;
    localparam logic [CFG_W-1:0] RST_REF_VELOCITY = 16'd307;
    localparam logic [CFG_W-1:0] RST_KP_GAIN      = 16'd11796;
    localparam logic [CFG_W-1:0] RST_KI_GAIN      = 16'd655;
    localparam logic [CFG_W-1:0] RST_DUTY_MAX     = 16'd13107;
    localparam logic [LEN_W-1:0] RST_AVG_LEN      = 7'd10;
    localparam logic [CFG_W-1:0] RST_WARMUP_DUTY  = 16'd6554;
    localparam logic             RST_USE_INTEGRAL = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_SPEED,
        ST_SPEED,
        ST_SELECT,
        ST_MUL_AVG,
        ST_DIV_START,
        ST_DIV,
        ST_DIV_DONE,
        ST_MUL_KI,
        ST_INTEG,
        ST_MUL_KP,
        ST_DUTY
    } state_t;

    typedef enum logic [1:0] {
        MUL_SPEED,
        MUL_AVG,
        MUL_KI,
        MUL_KP
    } mul_sel_t;

    typedef enum logic [1:0] {
        BR_WARM,
        BR_END,
        BR_STEADY
    } branch_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     speed_ld;
        logic     warm_upd;
        logic     div_start;
        logic     avg_ld;
        logic     integ_ld;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        branch_t branch;
        logic    count_zero;
        logic    div_busy;
        logic    out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/spcma_div.sv =====
// ============================================================================
// spcma_div
// Restoring divider, one quotient bit per cycle, for the window average.
// ============================================================================
`default_nettype none

module spcma_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [spcma_pkg::DIV_W-1:0]    dividend,
    input  wire logic [spcma_pkg::LEN_W-1:0]    divisor,
    output logic                                busy,
    output logic [spcma_pkg::DIV_W-1:0]         quotient
);

    localparam int DW    = spcma_pkg::DIV_W;
    localparam int LW    = spcma_pkg::LEN_W;
    localparam int CNT_W = $clog2(DW);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [LW-1:0]     rem_reg;
    logic [LW-1:0]     rem_next;
    logic [DW-1:0]     quo_reg;
    logic [DW-1:0]     quo_next;
    logic [LW:0]       trial;
    logic [LW:0]       diff;
    logic              ge;

    always_comb begin
        trial    = {rem_reg, quo_reg[DW-1]};
        ge       = trial >= {1'b0, divisor};
        diff     = trial - {1'b0, divisor};
        rem_next = ge ? diff[LW-1:0] : trial[LW-1:0];
        quo_next = {quo_reg[DW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/spcma_dp.sv =====
// ============================================================================
// spcma_dp
// Datapath: configuration registers, shared multiplier, averaging state,
// integral and duty clamps, and the result register.
// ============================================================================
`default_nettype none

module spcma_dp #(
    parameter int MAX_AVG_LEN  = spcma_pkg::MAX_AVG_LEN_DEF,
    parameter int WARMUP_TICKS = spcma_pkg::WARMUP_TICKS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wen,
    input  wire logic [spcma_pkg::ADDR_W-1:0]    cfg_addr,
    input  wire logic [spcma_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic [spcma_pkg::EDGE_W-1:0]    in_edge_count,
    input  wire spcma_pkg::cmd_t                 cmd,
    output spcma_pkg::sts_t                      sts,
    output logic [spcma_pkg::DUTY_W-1:0]         out_duty,
    output logic [spcma_pkg::CFG_W-1:0]          out_avg_speed,
    output logic                                 out_in_warmup,
    output logic                                 out_valid,
    input  wire logic                            out_ready
);

    localparam int EW    = spcma_pkg::EDGE_W;
    localparam int CW    = spcma_pkg::CFG_W;
    localparam int LW    = spcma_pkg::LEN_W;
    localparam int IW    = spcma_pkg::IDX_W;
    localparam int SW    = spcma_pkg::SUM_W;
    localparam int DW    = spcma_pkg::DIV_W;
    localparam int MW    = spcma_pkg::MUL_W;
    localparam int PW    = spcma_pkg::PROD_W;
    localparam int UW    = spcma_pkg::DUTY_W;
    localparam int SPW   = EW + CW - 4;
    localparam int TW    = PW - 8;
    localparam int AW    = TW + 1;
    localparam int WI_W  = $clog2(WARMUP_TICKS + 1);
    localparam logic [LW-1:0]   MAX_LEN_CLIP = LW'(MAX_AVG_LEN);
    localparam logic [WI_W-1:0] WARM_END     = WI_W'(WARMUP_TICKS);

    logic [CW-1:0] vel_scale_reg;
    logic [CW-1:0] ref_velocity_reg;
    logic [CW-1:0] kp_gain_reg;
    logic [CW-1:0] ki_gain_reg;
    logic [CW-1:0] duty_max_reg;
    logic [LW-1:0] avg_len_reg;
    logic [CW-1:0] warmup_duty_reg;
    logic          use_integral_reg;

    logic [EW-1:0]          count_reg;
    logic signed [PW-1:0]   prod_reg;
    logic [CW-1:0]          speed_reg;
    logic [SW-1:0]          sum_reg;
    logic [CW-1:0]          avg_reg;
    logic [UW-1:0]          integ_reg;
    logic [IW-1:0]          sample_idx_reg;
    logic [WI_W-1:0]        warm_idx_reg;
    logic [UW-1:0]          duty_out_reg;
    logic [CW-1:0]          avg_out_reg;
    logic                   warm_out_reg;
    logic                   out_valid_reg;

    logic [LW-1:0]          len;
    logic [LW-1:0]          len_m1;
    logic [IW-1:0]          len_ext;
    logic [IW-1:0]          len_p1;
    spcma_pkg::branch_t     branch;
    logic signed [MW-1:0]   mul_a;
    logic signed [MW-1:0]   mul_b;
    logic signed [PW-1:0]   mul_p;
    logic signed [MW-1:0]   err;
    logic [SPW-1:0]         speed_wide;
    logic [CW-1:0]          speed_sat;
    logic [SW:0]            sum_add;
    logic [SW-1:0]          sum_sat;
    logic [DW-1:0]          dividend;
    logic [DW-1:0]          quot;
    logic                   div_busy;
    logic [CW-1:0]          quot_sat;
    logic signed [TW-1:0]   term;
    logic signed [AW-1:0]   term_ext;
    logic signed [AW-1:0]   integ_ext;
    logic signed [AW-1:0]   dmax_ext;
    logic signed [AW-1:0]   integ_acc;
    logic signed [AW-1:0]   duty_acc;
    logic [UW-1:0]          integ_clamp;
    logic [UW-1:0]          duty_clamp;
    logic                   in_warm;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_scale_reg    <= spcma_pkg::RST_VEL_SCALE;
            ref_velocity_reg <= spcma_pkg::RST_REF_VELOCITY;
            kp_gain_reg      <= spcma_pkg::RST_KP_GAIN;
            ki_gain_reg      <= spcma_pkg::RST_KI_GAIN;
            duty_max_reg     <= spcma_pkg::RST_DUTY_MAX;
            avg_len_reg      <= spcma_pkg::RST_AVG_LEN;
            warmup_duty_reg  <= spcma_pkg::RST_WARMUP_DUTY;
            use_integral_reg <= spcma_pkg::RST_USE_INTEGRAL;
        end else if (cfg_wen) begin
            case (cfg_addr)
                spcma_pkg::REG_VEL_SCALE:    vel_scale_reg    <= cfg_wdata;
                spcma_pkg::REG_REF_VELOCITY: ref_velocity_reg <= cfg_wdata;
                spcma_pkg::REG_KP_GAIN:      kp_gain_reg      <= cfg_wdata;
                spcma_pkg::REG_KI_GAIN:      ki_gain_reg      <= cfg_wdata;
                spcma_pkg::REG_DUTY_MAX:     duty_max_reg     <= cfg_wdata;
                spcma_pkg::REG_AVG_LEN:      avg_len_reg      <= cfg_wdata[LW-1:0];
                spcma_pkg::REG_WARMUP_DUTY:  warmup_duty_reg  <= cfg_wdata;
                spcma_pkg::REG_USE_INTEGRAL: use_integral_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // window length and phase
    always_comb begin
        if (avg_len_reg == '0) begin
            len = LW'(1);
        end else if (int'(avg_len_reg) > MAX_AVG_LEN) begin
            len = MAX_LEN_CLIP;
        end else begin
            len = avg_len_reg;
        end
        len_m1  = len - 1'b1;
        len_ext = IW'(len);
        len_p1  = len_ext + 1'b1;
        if (sample_idx_reg < len_ext) begin
            branch = spcma_pkg::BR_WARM;
        end else if (sample_idx_reg == len_ext) begin
            branch = spcma_pkg::BR_END;
        end else begin
            branch = spcma_pkg::BR_STEADY;
        end
    end

    // shared multiplier operands
    always_comb begin
        err = $signed({1'b0, ref_velocity_reg}) - $signed({1'b0, avg_reg});
        case (cmd.mul_sel)
            spcma_pkg::MUL_SPEED: begin
                mul_a = $signed({1'b0, vel_scale_reg});
                mul_b = $signed({{(MW-EW){1'b0}}, count_reg});
            end
            spcma_pkg::MUL_AVG: begin
                mul_a = $signed({1'b0, avg_reg});
                mul_b = $signed({{(MW-LW){1'b0}}, len_m1});
            end
            spcma_pkg::MUL_KI: begin
                mul_a = $signed({1'b0, ki_gain_reg});
                mul_b = err;
            end
            default: begin
                mul_a = $signed({1'b0, kp_gain_reg});
                mul_b = err;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // speed, sum and dividend
    always_comb begin
        speed_wide = prod_reg[SPW+3:4];
        speed_sat  = (|speed_wide[SPW-1:CW]) ? '1 : speed_wide[CW-1:0];
        sum_add    = {1'b0, sum_reg} + (SW+1)'(speed_reg);
        sum_sat    = sum_add[SW] ? '1 : sum_add[SW-1:0];
        if (branch == spcma_pkg::BR_END) begin
            dividend = DW'(sum_add);
        end else begin
            dividend = DW'(prod_reg[DW-2:0]) + DW'(speed_reg);
        end
        quot_sat = (|quot[DW-1:CW]) ? '1 : quot[CW-1:0];
    end

    // integral and duty clamps
    always_comb begin
        term      = prod_reg[PW-1:8];
        term_ext  = {term[TW-1], term};
        integ_ext = $signed({{(AW-UW){1'b0}}, integ_reg});
        dmax_ext  = $signed({{(AW-UW){1'b0}}, duty_max_reg});
        integ_acc = integ_ext + term_ext;
        duty_acc  = term_ext + (use_integral_reg ? integ_ext : '0);
        if (integ_acc[AW-1]) begin
            integ_clamp = '0;
        end else if (integ_acc > dmax_ext) begin
            integ_clamp = duty_max_reg;
        end else begin
            integ_clamp = integ_acc[UW-1:0];
        end
        if (duty_acc[AW-1]) begin
            duty_clamp = '0;
        end else if (duty_acc > dmax_ext) begin
            duty_clamp = duty_max_reg;
        end else begin
            duty_clamp = duty_acc[UW-1:0];
        end
        in_warm = warm_idx_reg < WARM_END;
    end

    spcma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (len),
        .busy     (div_busy),
        .quotient (quot)
    );

    // controller state kept across words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg        <= '0;
            avg_reg        <= '0;
            integ_reg      <= '0;
            sample_idx_reg <= IW'(1);
            warm_idx_reg   <= WI_W'(1);
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.warm_upd) begin
                sum_reg        <= sum_sat;
                avg_reg        <= speed_reg;
                sample_idx_reg <= sample_idx_reg + 1'b1;
            end
            if (cmd.div_start) begin
                if (branch == spcma_pkg::BR_END) begin
                    sample_idx_reg <= sample_idx_reg + 1'b1;
                end else if (sample_idx_reg > len_p1) begin
                    sample_idx_reg <= len_p1;
                end
            end
            if (cmd.avg_ld) begin
                avg_reg <= quot_sat;
            end
            if (cmd.integ_ld) begin
                integ_reg <= integ_clamp;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
                if (in_warm) begin
                    warm_idx_reg <= warm_idx_reg + 1'b1;
                end
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            count_reg <= in_edge_count;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.speed_ld) begin
            speed_reg <= speed_sat;
        end
        if (cmd.out_load) begin
            duty_out_reg <= in_warm ? warmup_duty_reg : duty_clamp;
            avg_out_reg  <= avg_reg;
            warm_out_reg <= in_warm;
        end
    end

    always_comb begin
        sts.branch     = branch;
        sts.count_zero = in_edge_count == '0;
        sts.div_busy   = div_busy;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_duty      = duty_out_reg;
    assign out_avg_speed = avg_out_reg;
    assign out_in_warmup = warm_out_reg;
    assign out_valid     = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/spcma_ctrl.sv =====
// ============================================================================
// spcma_ctrl
// Sequencer: steps one word through speed, average, integral and duty.
// ============================================================================
`default_nettype none

module spcma_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire spcma_pkg::sts_t    sts,
    output spcma_pkg::cmd_t         cmd
);

    spcma_pkg::state_t state_reg;
    spcma_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spcma_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spcma_pkg::ST_IDLE: begin
                if (in_valid && !sts.count_zero) begin
                    state_next = spcma_pkg::ST_MUL_SPEED;
                end
            end
            spcma_pkg::ST_MUL_SPEED: state_next = spcma_pkg::ST_SPEED;
            spcma_pkg::ST_SPEED:     state_next = spcma_pkg::ST_SELECT;
            spcma_pkg::ST_SELECT: begin
                case (sts.branch)
                    spcma_pkg::BR_WARM: state_next = spcma_pkg::ST_MUL_KI;
                    spcma_pkg::BR_END:  state_next = spcma_pkg::ST_DIV;
                    default:            state_next = spcma_pkg::ST_DIV_START;
                endcase
            end
            spcma_pkg::ST_DIV_START: state_next = spcma_pkg::ST_DIV;
            spcma_pkg::ST_DIV: begin
                if (!sts.div_busy) begin
                    state_next = spcma_pkg::ST_DIV_DONE;
                end
            end
            spcma_pkg::ST_DIV_DONE: state_next = spcma_pkg::ST_MUL_KI;
            spcma_pkg::ST_MUL_KI:   state_next = spcma_pkg::ST_INTEG;
            spcma_pkg::ST_INTEG:    state_next = spcma_pkg::ST_MUL_KP;
            spcma_pkg::ST_MUL_KP:   state_next = spcma_pkg::ST_DUTY;
            spcma_pkg::ST_DUTY: begin
                if (sts.out_free) begin
                    state_next = spcma_pkg::ST_IDLE;
                end
            end
            default: state_next = spcma_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            spcma_pkg::ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            spcma_pkg::ST_MUL_SPEED: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = spcma_pkg::MUL_SPEED;
            end
            spcma_pkg::ST_SPEED: begin
                cmd.speed_ld = 1'b1;
            end
            spcma_pkg::ST_SELECT: begin
                case (sts.branch)
                    spcma_pkg::BR_WARM: cmd.warm_upd  = 1'b1;
                    spcma_pkg::BR_END:  cmd.div_start = 1'b1;
                    default: begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = spcma_pkg::MUL_AVG;
                    end
                endcase
            end
            spcma_pkg::ST_DIV_START: begin
                cmd.div_start = 1'b1;
            end
            spcma_pkg::ST_DIV_DONE: begin
                cmd.avg_ld = 1'b1;
            end
            spcma_pkg::ST_MUL_KI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = spcma_pkg::MUL_KI;
            end
            spcma_pkg::ST_INTEG: begin
                cmd.integ_ld = 1'b1;
            end
            spcma_pkg::ST_MUL_KP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = spcma_pkg::MUL_KP;
            end
            spcma_pkg::ST_DUTY: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/speed_pi_controller_moving_average_core.sv =====
// ============================================================================
// speed_pi_controller_moving_average_core
// A word steps through speed, select, Ki, integral, Kp and duty in warm-up of
// the average; at the window end and once the average is exponential, a
// 24-bit restoring divide follows select. One word is worked on at a time; a
// zero count is taken with no result. The result register lets the next word in.
// Reset: synchronous active-low aresetn restores register defaults and state.
// ============================================================================
`default_nettype none

module speed_pi_controller_moving_average_core #(
    parameter int MAX_AVG_LEN  = spcma_pkg::MAX_AVG_LEN_DEF,
    parameter int WARMUP_TICKS = spcma_pkg::WARMUP_TICKS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,   // edge_count[9:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [31:0]                          m_tdata,   // avg_speed[31:16], duty[15:0]
    output logic                                 m_tuser,   // in_warmup
    input  wire logic                            cfg_wen,
    input  wire logic [spcma_pkg::ADDR_W-1:0]    cfg_addr,
    input  wire logic [spcma_pkg::CFG_W-1:0]     cfg_wdata
);

    spcma_pkg::cmd_t               cmd;
    spcma_pkg::sts_t               sts;
    logic [spcma_pkg::DUTY_W-1:0]  duty;
    logic [spcma_pkg::CFG_W-1:0]   avg_speed;

    spcma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spcma_dp #(
        .MAX_AVG_LEN  (MAX_AVG_LEN),
        .WARMUP_TICKS (WARMUP_TICKS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_edge_count (s_tdata[spcma_pkg::EDGE_W-1:0]),
        .cmd           (cmd),
        .sts           (sts),
        .out_duty      (duty),
        .out_avg_speed (avg_speed),
        .out_in_warmup (m_tuser),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready)
    );

    assign m_tdata = {avg_speed, duty};

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending word");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider restarted while busy");

    a_ready_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.div_busy)
        else $error("input ready while divider busy");

    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !sts.count_zero) |=> !s_tready)
        else $error("ready held after accepting a live word");
`endif

endmodule

`default_nettype wire
